// File: src/btl_pkg.sv
// shared types, constants and codes for the barycentric triangle locator
`default_nettype none
package btl_pkg;

    localparam int MaxVertices  = 64;
    localparam int MaxTriangles = 128;
    localparam int CoordW       = 16;
    localparam int WeightW      = 20;
    localparam int FracBits     = 16;
    localparam int CountW       = 8;

    typedef enum logic [1:0] {
        OP_VERTEX   = 2'd0,
        OP_TRIANGLE = 2'd1,
        OP_QUERY    = 2'd2,
        OP_NONE     = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [6:0]  entry_index;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic [5:0]  corner_a;
        logic [5:0]  corner_b;
        logic [5:0]  corner_c;
    } t_in_item;

    typedef struct packed {
        logic        inside_res;
        logic [6:0]  triangle_index;
        logic [5:0]  vertex_first;
        logic [5:0]  vertex_second;
        logic [5:0]  vertex_third;
        logic signed [19:0] weight_u;
        logic signed [19:0] weight_v;
        logic signed [19:0] weight_w;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRI_RD,
        ST_TRI_WAIT,
        ST_V0,
        ST_V1,
        ST_V2,
        ST_VWAIT,
        ST_ARITH,
        ST_DIV,
        ST_DECIDE,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic start;       // latch query point, clear search
        logic tri_rd;      // issue triangle store read
        logic tri_cap;     // capture corners
        logic [1:0] vsel;  // which corner to read
        logic v_rd;        // issue vertex read
        logic v_cap;       // capture previous vertex read
        logic arith;       // step arithmetic pipeline
        logic div_start;   // launch dividers
        logic decide;      // evaluate inside / distance
        logic next_tri;    // advance triangle index
        logic load_out;    // load result register
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic arith_done;
        logic div_done;
        logic found;
        logic last_tri;
        logic refetch;     // fallback pass in progress
    } t_sts;

endpackage
`default_nettype wire

// File: src/barycentric_triangle_locator_core.sv
// top level of the barycentric triangle locator
`default_nettype none
// Vertex and triangle writes give no item. A query walks triangles 0 to
// triangle_count-1 in order; for each, the controller steps through the
// triangle store read, the vertex reads, the product pipeline, the two
// 51-step radix-2 dividers that form v and w in parallel, and a decide
// step. The walk stops at the first triangle that holds the point; if no
// triangle holds the point the nearest centroid triangle is fetched once
// more. The result item is then loaded once the output register is free.
// One query is handled at a time and the input stalls until its result item
// sits in the output register.
module barycentric_triangle_locator_core #(
    parameter int MaxVertices  = btl_pkg::MaxVertices,
    parameter int MaxTriangles = btl_pkg::MaxTriangles
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [7:0]          i_cfg_wdata,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  btl_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output btl_pkg::t_out_item o_out_item
);
    logic [7:0] r_count;
    logic w_acc, w_busy, w_query;
    btl_pkg::t_ctl w_ctl;
    btl_pkg::t_sts w_sts;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= 8'd1;
        else if (i_cfg_we) r_count <= i_cfg_wdata;
    end

    assign o_in_stall = w_busy;
    assign w_acc   = i_in_valid && !o_in_stall;
    assign w_query = w_acc && i_in_item.opcode == btl_pkg::OP_QUERY;

    btl_ctrl u_ctrl (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_query(w_query),
        .i_out_busy(o_out_valid && i_out_stall), .i_sts(w_sts), .o_ctl(w_ctl),
        .o_busy(w_busy));

    btl_dpath #(.MaxVertices(MaxVertices), .MaxTriangles(MaxTriangles)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(w_acc), .i_item(i_in_item),
        .i_count(r_count), .i_ctl(w_ctl), .o_sts(w_sts), .o_res(o_out_item));

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_out_valid <= 1'b0;
        else if (w_ctl.load_out) o_out_valid <= 1'b1;
        else if (!i_out_stall) o_out_valid <= 1'b0;
    end

`ifndef SYNTH
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load_out |-> !(o_out_valid && i_out_stall))
        else $error("result loaded over a waiting item");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_query |=> w_busy)
        else $error("query did not start the walk");
`endif
endmodule
`default_nettype wire

// File: src/btl_ram.sv
// generic single port write, single port registered read ram
`default_nettype none
module btl_ram #(
    parameter int Width = 16,
    parameter int Depth = 64
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(Depth)-1:0] i_waddr,
    input  wire [Width-1:0]         i_wdata,
    input  wire [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]        o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: src/btl_div.sv
// radix-2 restoring divider for rounded fixed point weights
`default_nettype none
module btl_div (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire signed [34:0] i_num,
    input  wire signed [33:0] i_den,
    output logic              o_done,
    output logic signed [53:0] o_quot
);
    // |num|*65536 needs 51 bits, quotient of same width
    localparam int NW = 51;
    localparam int DW = 33;

    logic [NW-1:0] r_q, n_q;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic          r_neg;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_shift;
    logic [34:0]   w_an;
    logic [33:0]   w_ad;
    logic [NW:0]   w_round;

    assign w_an = i_num[34] ? 35'(-i_num) : 35'(i_num);
    assign w_ad = i_den[33] ? 34'(-i_den) : 34'(i_den);

    // one quotient bit per cycle
    always_comb begin
        w_shift = {r_rem[DW-1:0], r_q[NW-1]};
        w_trial = w_shift - {1'b0, r_den};
        n_q     = {r_q[NW-2:0], ~w_trial[DW]};
        n_rem   = w_trial[DW] ? w_shift : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            o_done <= 1'b0;
            r_cnt  <= 6'(NW);
        end else if (r_busy) begin
            if (r_cnt == 6'd0) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    // quotient of (|n|*65536 + |d|/2) / |d|
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= NW'({w_an[34:0], 16'd0} + {18'd0, w_ad[33:1]});
            r_rem <= '0;
            r_den <= w_ad[DW-1:0];
            r_neg <= i_num[34] ^ i_den[33];
        end else if (r_busy && r_cnt != 6'd0) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign w_round = {1'b0, r_q};
    assign o_quot  = r_neg ? -54'(w_round) : 54'(w_round);
endmodule
`default_nettype wire

// File: src/btl_ctrl.sv
// controller state machine for the triangle walk
`default_nettype none
module btl_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_query,
    input  wire            i_out_busy,
    input  btl_pkg::t_sts  i_sts,
    output btl_pkg::t_ctl  o_ctl,
    output logic           o_busy
);
    btl_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            btl_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_query) begin
                    o_ctl.start = 1'b1;
                    n_state = btl_pkg::ST_TRI_RD;
                end
            end
            btl_pkg::ST_TRI_RD: begin
                o_ctl.tri_rd = 1'b1;
                n_state = btl_pkg::ST_TRI_WAIT;
            end
            btl_pkg::ST_TRI_WAIT: begin
                o_ctl.tri_cap = 1'b1;
                n_state = btl_pkg::ST_V0;
            end
            btl_pkg::ST_V0: begin
                o_ctl.v_rd = 1'b1;
                o_ctl.vsel = 2'd0;
                n_state = btl_pkg::ST_V1;
            end
            btl_pkg::ST_V1: begin
                o_ctl.v_rd = 1'b1;
                o_ctl.vsel = 2'd1;
                o_ctl.v_cap = 1'b1;
                n_state = btl_pkg::ST_V2;
            end
            btl_pkg::ST_V2: begin
                o_ctl.v_rd = 1'b1;
                o_ctl.vsel = 2'd2;
                o_ctl.v_cap = 1'b1;
                n_state = btl_pkg::ST_VWAIT;
            end
            btl_pkg::ST_VWAIT: begin
                o_ctl.v_cap = 1'b1;
                o_ctl.vsel = 2'd3;
                n_state = btl_pkg::ST_ARITH;
            end
            btl_pkg::ST_ARITH: begin
                o_ctl.arith = 1'b1;
                if (i_sts.arith_done) begin
                    o_ctl.div_start = 1'b1;
                    n_state = btl_pkg::ST_DIV;
                end
            end
            btl_pkg::ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = btl_pkg::ST_DECIDE;
                end
            end
            btl_pkg::ST_DECIDE: begin
                o_ctl.decide = 1'b1;
                if (i_sts.refetch || i_sts.found) begin
                    n_state = btl_pkg::ST_OUT;
                end else if (i_sts.last_tri) begin
                    // refetch the nearest triangle for its weights
                    o_ctl.next_tri = 1'b1;
                    n_state = btl_pkg::ST_TRI_RD;
                end else begin
                    o_ctl.next_tri = 1'b1;
                    n_state = btl_pkg::ST_TRI_RD;
                end
            end
            btl_pkg::ST_OUT: begin
                if (!i_out_busy) begin
                    o_ctl.load_out = 1'b1;
                    n_state = btl_pkg::ST_IDLE;
                end
            end
            default: n_state = btl_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: src/btl_dpath.sv
// datapath: stores, arithmetic, dividers and search registers
`default_nettype none
module btl_dpath #(
    parameter int MaxVertices  = btl_pkg::MaxVertices,
    parameter int MaxTriangles = btl_pkg::MaxTriangles
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_wr,
    input  btl_pkg::t_in_item i_item,
    input  wire [7:0]        i_count,
    input  btl_pkg::t_ctl    i_ctl,
    output btl_pkg::t_sts    o_sts,
    output btl_pkg::t_out_item o_res
);
    localparam int VA = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
    localparam int TA = (MaxTriangles > 1) ? $clog2(MaxTriangles) : 1;
    localparam int TIW = TA + 1;

    // stores
    logic w_vwe, w_twe;
    logic [15:0] w_vx, w_vy;
    logic [17:0] w_tc;
    logic [VA-1:0] w_vra;
    logic [TA-1:0] w_tra;
    logic [TIW-1:0] r_ti, r_best, r_n;
    logic w_inside;

    assign w_vwe = i_wr && i_item.opcode == btl_pkg::OP_VERTEX
                   && 32'(i_item.entry_index) < 32'(MaxVertices);
    assign w_twe = i_wr && i_item.opcode == btl_pkg::OP_TRIANGLE
                   && 32'(i_item.entry_index) < 32'(MaxTriangles);

    btl_ram #(.Width(16), .Depth(MaxVertices)) u_vx (
        .i_clk(i_clk), .i_we(w_vwe), .i_waddr(VA'(i_item.entry_index)),
        .i_wdata(i_item.coord_x), .i_raddr(w_vra), .o_rdata(w_vx));
    btl_ram #(.Width(16), .Depth(MaxVertices)) u_vy (
        .i_clk(i_clk), .i_we(w_vwe), .i_waddr(VA'(i_item.entry_index)),
        .i_wdata(i_item.coord_y), .i_raddr(w_vra), .o_rdata(w_vy));
    btl_ram #(.Width(18), .Depth(MaxTriangles)) u_tri (
        .i_clk(i_clk), .i_we(w_twe), .i_waddr(TA'(i_item.entry_index)),
        .i_wdata({i_item.corner_c, i_item.corner_b, i_item.corner_a}),
        .i_raddr(w_tra), .o_rdata(w_tc));

    logic r_refetch, r_found;
    logic [17:0] r_tc;
    logic signed [15:0] r_px, r_py;
    logic signed [16:0] r_x [3];
    logic signed [16:0] r_y [3];
    logic [1:0] r_vcap;
    logic r_vrs;  // range flag of read in flight
    logic [5:0] w_corner;

    assign w_tra = r_refetch ? TA'(r_best) : TA'(r_ti);
    always_comb begin
        unique case (i_ctl.vsel)
            2'd0: w_corner = r_tc[5:0];
            2'd1: w_corner = r_tc[11:6];
            default: w_corner = r_tc[17:12];
        endcase
    end
    assign w_vra = VA'(w_corner);

    // query setup, triangle and vertex capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refetch <= 1'b0;
            r_found   <= 1'b0;
            r_ti      <= '0;
            r_vcap    <= '0;
        end else begin
            if (i_ctl.start) begin
                r_px <= i_item.coord_x;
                r_py <= i_item.coord_y;
                r_refetch <= 1'b0;
                r_found <= 1'b0;
                r_ti <= '0;
                if (i_count == 8'd0) r_n <= TIW'(1);
                else if (32'(i_count) > MaxTriangles) r_n <= TIW'(MaxTriangles);
                else r_n <= TIW'(i_count);
            end
            if (i_ctl.tri_cap) begin
                r_tc <= w_tc;
                r_vcap <= '0;
            end
            if (i_ctl.v_rd) begin
                r_vrs <= 32'(w_corner) < 32'(MaxVertices);
            end
            if (i_ctl.v_cap) begin
                r_x[r_vcap] <= r_vrs ? 17'(signed'(w_vx)) : '0;
                r_y[r_vcap] <= r_vrs ? 17'(signed'(w_vy)) : '0;
                r_vcap <= r_vcap + 2'd1;
            end
            if (i_ctl.next_tri) begin
                if (r_ti + TIW'(1) >= r_n) r_refetch <= 1'b1;
                else r_ti <= r_ti + TIW'(1);
            end
            if (i_ctl.decide && !r_refetch && w_inside) r_found <= 1'b1;
        end
    end

    // arithmetic: stage 0 differences, stage 1 products, stage 2 sums, stage 3 hold
    logic [1:0] r_ast;
    logic signed [16:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic signed [18:0] r_ex, r_ey;
    logic signed [33:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [35:0] r_q0, r_q1;
    logic signed [33:0] r_den;
    logic signed [34:0] r_nv, r_nw;
    logic [37:0] r_dist, r_bdist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ast <= '0;
        end else if (i_ctl.arith) begin
            r_ast <= r_ast + 2'd1;
        end else begin
            r_ast <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.arith) begin
            unique case (r_ast)
                2'd0: begin
                    r_a <= r_x[1] - r_x[0];
                    r_b <= r_y[2] - r_y[0];
                    r_c <= r_x[2] - r_x[0];
                    r_d <= r_y[1] - r_y[0];
                    r_e <= r_x[0] - r_x[2];
                    r_f <= 17'(r_py) - r_y[2];
                    r_g <= 17'(r_px) - r_x[2];
                    r_h <= r_y[0] - r_y[2];
                    r_ex <= 19'(3 * 19'(signed'(r_px))) - 19'(r_x[0] + r_x[1] + r_x[2]);
                    r_ey <= 19'(3 * 19'(signed'(r_py))) - 19'(r_y[0] + r_y[1] + r_y[2]);
                end
                2'd1: begin
                    r_p0 <= r_a * r_b;
                    r_p1 <= r_c * r_d;
                    r_p2 <= r_e * r_f;
                    r_p3 <= r_g * r_h;
                    r_p4 <= r_a * (17'(r_py) - r_y[0]);
                    r_p5 <= (17'(r_px) - r_x[0]) * r_d;
                    r_q0 <= r_ex * r_ex;
                    r_q1 <= r_ey * r_ey;
                end
                default: begin
                    r_den  <= r_p0 - r_p1;
                    r_nv   <= 35'(r_p2) - 35'(r_p3);
                    r_nw   <= 35'(r_p4) - 35'(r_p5);
                    r_dist <= 38'(unsigned'(r_q0)) + 38'(unsigned'(r_q1));
                end
            endcase
        end
    end

    // dividers for v and w
    logic w_dv, w_dw;
    logic signed [53:0] w_qv, w_qw;
    btl_div u_div_v (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_ctl.div_start),
        .i_num(r_nv), .i_den(r_den), .o_done(w_dv), .o_quot(w_qv));
    btl_div u_div_w (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_ctl.div_start),
        .i_num(r_nw), .i_den(r_den), .o_done(w_dw), .o_quot(w_qw));

    // exact inside test on the unrounded values
    logic signed [35:0] w_an, w_aw, w_ad, w_as;
    always_comb begin
        w_ad = r_den[33] ? -36'(r_den) : 36'(r_den);
        w_an = r_den[33] ? -36'(r_nv) : 36'(r_nv);
        w_aw = r_den[33] ? -36'(r_nw) : 36'(r_nw);
        w_as = w_an + w_aw;
        w_inside = (r_den != '0) && w_an >= 0 && w_an <= w_ad && w_aw >= 0
                   && w_aw <= w_ad && w_as >= 0 && w_as <= w_ad;
    end

    // saturated weights
    function automatic logic signed [19:0] sat20(input logic signed [55:0] v);
        if (v > 56'sd524287) return 20'sd524287;
        if (v < -56'sd524288) return -20'sd524288;
        return v[19:0];
    endfunction

    logic signed [55:0] w_u, w_v, w_w;
    always_comb begin
        if (r_den == '0) begin
            w_v = '0;
            w_w = '0;
        end else begin
            w_v = 56'(w_qv);
            w_w = 56'(w_qw);
        end
        w_u = 56'sd65536 - w_v - w_w;
    end

    // best centroid tracking
    always_ff @(posedge i_clk) begin
        if (i_ctl.decide && !r_refetch && !w_inside) begin
            if (r_ti == '0 || r_dist < r_bdist) begin
                r_bdist <= r_dist;
                r_best <= r_ti;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            o_res.inside_res     <= r_found;
            o_res.triangle_index <= 7'(r_refetch ? r_best : r_ti);
            o_res.vertex_first   <= r_tc[5:0];
            o_res.vertex_second  <= r_tc[11:6];
            o_res.vertex_third   <= r_tc[17:12];
            o_res.weight_u       <= sat20(w_u);
            o_res.weight_v       <= sat20(w_v);
            o_res.weight_w       <= sat20(w_w);
        end
    end

    assign o_sts.arith_done = (r_ast == 2'd3);
    assign o_sts.div_done   = w_dv && w_dw;
    assign o_sts.found      = !r_refetch && w_inside;
    assign o_sts.last_tri   = (r_ti + TIW'(1) >= r_n);
    assign o_sts.refetch    = r_refetch;
endmodule
`default_nettype wire
